### design/stereo_fir_convolver_defines.svh
// Assertion helpers shared by the convolver modules.
`ifndef STEREO_FIR_CONVOLVER_DEFINES_SVH
`define STEREO_FIR_CONVOLVER_DEFINES_SVH

// Check a property on every rising edge, ignoring cycles in reset.
`define SFIR_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define SFIR_ASSERT_NORST(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

### design/sfir_pkg.sv
package sfir_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int COEFF_BITS       = 24;
  localparam int GAIN_BITS        = 16;
  localparam int GAIN_FRAC        = 12;
  localparam int TAP_INDEX_BITS   = 12;
  localparam int TAP_COUNT_BITS   = 13;
  localparam int MAX_TAPS_DEFAULT = 4096;
  localparam int CHANNELS         = 2;
  localparam int CFG_ADDR_BITS    = 4;
  localparam int CFG_DATA_BITS    = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET          = 16'd4096;
  localparam logic                 ACTIVE_RESET        = 1'b0;
  localparam logic [1:0]           CHANNELS_USED_RESET = 2'd2;

  typedef enum logic [1:0] {
    OP_FRAME,
    OP_COEF,
    OP_TAPS,
    OP_CLEAR
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_BAD_CHANNEL,
    STATUS_TOO_MANY_TAPS
  } status_t;

  typedef enum logic [1:0] {
    REG_GAIN,
    REG_ACTIVE,
    REG_CHANNELS_USED
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_CLEAR_ITEM,
    ST_IDLE,
    ST_DECODE,
    ST_CHAN,
    ST_MAC,
    ST_DRAIN,
    ST_ROUND,
    ST_SCALE,
    ST_SAT,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    opcode_t                        opcode;
    logic signed [SAMPLE_BITS-1:0]  sample_left;
    logic signed [SAMPLE_BITS-1:0]  sample_right;
    logic                           channel_select;
    logic [TAP_INDEX_BITS-1:0]      tap_index;
    logic signed [COEFF_BITS-1:0]   tap_value;
    logic [TAP_COUNT_BITS-1:0]      tap_count;
  } item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] result_left;
    logic signed [SAMPLE_BITS-1:0] result_right;
    status_t                       status;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic coef_wr;
    logic taps_wr;
    logic clear_step;
    logic mac_start;
    logic mac_issue;
    logic round;
    logic scale;
    logic sat;
    logic finish;
    logic ch;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    opcode_t opcode;
    logic    filt;
    logic    mac_last;
    logic    pipe_busy;
    logic    clear_last;
  } stat_t;

endpackage

### design/sfir_ctrl.sv
`include "stereo_fir_convolver_defines.svh"

module sfir_ctrl
  import sfir_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  output logic  result_valid,
  input  logic  result_ready,
  input  logic  clear_req,
  input  stat_t stat,
  output cmd_t  cmd
);

  ctrl_state_t state, state_next;
  logic        ch, ch_next;
  logic        out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      ch           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      if (cmd.finish) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ch_next    = ch;
    case (state)
      ST_CLEAR: begin
        if (stat.clear_last) state_next = ST_IDLE;
      end
      ST_CLEAR_ITEM: begin
        if (stat.clear_last) state_next = ST_DONE;
      end
      ST_IDLE: begin
        if (clear_req) begin
          state_next = ST_CLEAR;
        end else if (item_valid) begin
          state_next = ST_DECODE;
          ch_next    = 1'b0;
        end
      end
      ST_DECODE: begin
        case (stat.opcode)
          OP_FRAME: state_next = ST_CHAN;
          OP_CLEAR: state_next = ST_CLEAR_ITEM;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_CHAN: begin
        if (stat.filt) begin
          state_next = ST_MAC;
        end else if (ch) begin
          state_next = ST_DONE;
        end else begin
          ch_next = 1'b1;
        end
      end
      ST_MAC: begin
        if (stat.mac_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_ROUND;
      end
      ST_ROUND: state_next = ST_SCALE;
      ST_SCALE: state_next = ST_SAT;
      ST_SAT: begin
        if (ch) begin
          state_next = ST_DONE;
        end else begin
          ch_next    = 1'b1;
          state_next = ST_CHAN;
        end
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.ch         = ch;
    cmd.clear_step = state inside {ST_CLEAR, ST_CLEAR_ITEM};
    item_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready  = !clear_req;
        cmd.capture = item_valid && !clear_req;
      end
      ST_DECODE: begin
        cmd.coef_wr = (stat.opcode == OP_COEF);
        cmd.taps_wr = (stat.opcode == OP_TAPS);
      end
      ST_CHAN:  cmd.mac_start = stat.filt;
      ST_MAC:   cmd.mac_issue = 1'b1;
      ST_ROUND: cmd.round     = 1'b1;
      ST_SCALE: cmd.scale     = 1'b1;
      ST_SAT:   cmd.sat       = 1'b1;
      ST_DONE:  cmd.finish    = out_free;
      default: ;
    endcase
  end

  `SFIR_ASSERT_NORST(a_reset_to_clear, clk, rst |=> (state == ST_CLEAR), "reset did not start the clearing pass")
  `SFIR_ASSERT(a_result_from_done, clk, rst, $rose(result_valid) |-> $past(state == ST_DONE), "result raised outside completion")
  `SFIR_ASSERT(a_accept_decodes, clk, rst, (item_valid && item_ready) |=> (state == ST_DECODE), "accepted beat not decoded")

endmodule

### design/sfir_datapath.sv
`include "stereo_fir_convolver_defines.svh"

module sfir_datapath
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  item_t                item,
  input  cmd_t                 cmd,
  input  logic                 active,
  input  logic [1:0]           channels_used,
  input  logic [GAIN_BITS-1:0] gain,
  output stat_t                stat,
  output result_t              result
);

  localparam int POS_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int PROD_W = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_W  = PROD_W + CNT_W;
  localparam int RSH    = COEFF_BITS - 1;
  localparam int RF_W   = ACC_W + 1 - RSH;
  // Beyond 2^(SAMPLE_BITS+GAIN_FRAC) any non-zero gain saturates, so clamp there.
  localparam int R_W    = SAMPLE_BITS + GAIN_FRAC + 2;
  localparam int SC_W   = R_W + GAIN_BITS + 1;
  localparam int Y_W    = SC_W - GAIN_FRAC;

  localparam logic [POS_W-1:0]        LAST_POS = POS_W'(MAX_TAPS - 1);
  localparam logic signed [ACC_W:0]   ACC_RND  = (ACC_W + 1)'(1) << (RSH - 1);
  localparam logic signed [63:0]      R_LIM    = 64'sd1 <<< (R_W - 2);
  localparam logic signed [SC_W-1:0]  SC_RND   = SC_W'(1) << (GAIN_FRAC - 1);
  localparam logic signed [Y_W-1:0]   Y_MAX    = Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [Y_W-1:0]   Y_MIN    = -Y_MAX - Y_W'(1);

  item_t                          cur;
  logic [CNT_W-1:0]               taps [CHANNELS];
  logic [POS_W-1:0]               pos;
  logic [POS_W-1:0]               q;
  logic [POS_W-1:0]               clr_addr;
  logic [CNT_W-1:0]               k;
  logic signed [SAMPLE_BITS-1:0]  y [CHANNELS];
  logic signed [COEFF_BITS-1:0]   coef_rd [CHANNELS];
  logic signed [SAMPLE_BITS-1:0]  hist_rd [CHANNELS];
  logic                           rd_v;
  logic                           prod_v;
  logic signed [PROD_W-1:0]       prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [R_W-1:0]          r;
  logic signed [SC_W-1:0]         scaled;

  logic                           ch_bad;
  logic [31:0]                    idx_ext;
  logic [31:0]                    cnt_ext;
  logic                           idx_ok;
  logic                           cnt_ok;
  logic                           coef_we;
  logic                           taps_we;
  status_t                        status_code;
  logic signed [ACC_W:0]          acc_rnd;
  logic signed [RF_W-1:0]         r_full;
  logic signed [63:0]             r_wide;
  logic signed [R_W-1:0]          r_next;
  logic signed [SC_W-1:0]         sc_rnd;
  logic signed [Y_W-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0]  y_next;

  // Decode of the held item.
  always_comb begin
    ch_bad  = cur.channel_select && (channels_used == 2'd1);
    idx_ext = 32'(cur.tap_index);
    cnt_ext = 32'(cur.tap_count);
    idx_ok  = idx_ext < 32'(MAX_TAPS);
    cnt_ok  = cnt_ext <= 32'(MAX_TAPS);
    coef_we = cmd.coef_wr && !ch_bad && idx_ok;
    taps_we = cmd.taps_wr && !ch_bad && cnt_ok;
    case (cur.opcode)
      OP_COEF: status_code = ch_bad ? STATUS_BAD_CHANNEL : STATUS_OK;
      OP_TAPS: begin
        if (ch_bad) begin
          status_code = STATUS_BAD_CHANNEL;
        end else if (!cnt_ok) begin
          status_code = STATUS_TOO_MANY_TAPS;
        end else begin
          status_code = STATUS_OK;
        end
      end
      default: status_code = STATUS_OK;
    endcase
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic signed [COEFF_BITS-1:0]  coef_mem [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic signed [COEFF_BITS-1:0]  coef_q;
    logic signed [SAMPLE_BITS-1:0] hist_q;
    logic                          hist_we;
    logic [POS_W-1:0]              hist_wa;
    logic signed [SAMPLE_BITS-1:0] hist_wd;

    always_comb begin
      hist_we = cmd.clear_step || (cmd.mac_start && (cmd.ch == 1'(c)));
      hist_wa = cmd.clear_step ? clr_addr : pos;
      hist_wd = cmd.clear_step ? '0 : ((c == 0) ? cur.sample_left : cur.sample_right);
    end

    always_ff @(posedge clk) begin
      if (coef_we && (cur.channel_select == 1'(c))) begin
        coef_mem[idx_ext[POS_W-1:0]] <= cur.tap_value;
      end
      if (hist_we) begin
        hist_mem[hist_wa] <= hist_wd;
      end
      coef_q <= coef_mem[k[POS_W-1:0]];
      hist_q <= hist_mem[q];
    end

    assign coef_rd[c] = coef_q;
    assign hist_rd[c] = hist_q;
  end

  // Round to Q15.23, clamp, scale by gain, round and saturate to Q1.23.
  always_comb begin
    acc_rnd = (ACC_W + 1)'(acc) + ACC_RND;
    r_full  = RF_W'(acc_rnd >>> RSH);
    r_wide  = 64'(r_full);
    if (r_wide > R_LIM) begin
      r_next = R_W'(R_LIM);
    end else if (r_wide < -R_LIM) begin
      r_next = R_W'(-R_LIM);
    end else begin
      r_next = R_W'(r_wide);
    end
    sc_rnd = scaled + SC_RND;
    y_full = Y_W'(sc_rnd >>> GAIN_FRAC);
    if (y_full > Y_MAX) begin
      y_next = SAMPLE_BITS'(Y_MAX);
    end else if (y_full < Y_MIN) begin
      y_next = SAMPLE_BITS'(Y_MIN);
    end else begin
      y_next = SAMPLE_BITS'(y_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      clr_addr <= '0;
      taps[0]  <= '0;
      taps[1]  <= '0;
      rd_v     <= 1'b0;
      prod_v   <= 1'b0;
    end else begin
      rd_v   <= cmd.mac_issue;
      prod_v <= rd_v;
      if (cmd.clear_step) begin
        clr_addr <= (clr_addr == LAST_POS) ? '0 : clr_addr + 1'b1;
        pos      <= '0;
      end else if (cmd.finish && (cur.opcode == OP_FRAME) && active) begin
        pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
      end
      if (taps_we) begin
        taps[cur.channel_select] <= CNT_W'(cur.tap_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur  <= item;
      y[0] <= (item.opcode == OP_FRAME) ? item.sample_left : '0;
      y[1] <= (item.opcode == OP_FRAME) ? item.sample_right : '0;
    end
    if (cmd.mac_start) begin
      k   <= '0;
      q   <= pos;
      acc <= '0;
    end
    if (cmd.mac_issue) begin
      k <= k + 1'b1;
      q <= (q == '0) ? LAST_POS : q - 1'b1;
    end
    if (rd_v) begin
      prod <= coef_rd[cmd.ch] * hist_rd[cmd.ch];
    end
    if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.round) begin
      r <= r_next;
    end
    if (cmd.scale) begin
      scaled <= r * $signed({1'b0, gain});
    end
    if (cmd.sat) begin
      y[cmd.ch] <= y_next;
    end
    if (cmd.finish) begin
      result <= '{result_left: y[0], result_right: y[1], status: status_code};
    end
  end

  always_comb begin
    stat.opcode     = cur.opcode;
    stat.filt       = active && (!cmd.ch || (channels_used != 2'd1))
                      && (taps[cmd.ch] != '0);
    stat.mac_last   = (k + 1'b1) == taps[cmd.ch];
    stat.pipe_busy  = rd_v || prod_v;
    stat.clear_last = (clr_addr == LAST_POS);
  end

  `SFIR_ASSERT(a_round_drained, clk, rst, cmd.round |-> !(rd_v || prod_v), "rounding before the accumulator drained")
  `SFIR_ASSERT(a_issue_in_range, clk, rst, cmd.mac_issue |-> (k < taps[cmd.ch]), "tap walk ran past the tap count")
  `SFIR_ASSERT(a_pos_moves, clk, rst, (pos != $past(pos)) |-> $past(cmd.clear_step || cmd.finish), "ring position moved without a frame or clear")

endmodule

### design/stereo_fir_convolver.sv
// Stereo direct-form FIR convolver. Each input beat carries an opcode: a frame
// beat holds one Q1.23 sample per channel and returns one filtered sample per
// channel, while coefficient, tap-count and clear-history beats update state and
// return a status (0 ok, 1 channel not in use, 2 tap count above MAX_TAPS) with
// zero samples. Every input beat yields exactly one result beat. A channel in use
// with a non-zero tap count stores its sample in its history ring and sums
// coefficient times history, newest first, then rounds, scales by the unsigned
// Q4.12 gain and saturates; any other channel, or the whole block while active is
// 0, passes samples straight through. One shared multiply-accumulate reads one
// coefficient and one history word per cycle, so the filtering channels of a
// frame are summed one after the other. The history memories are zeroed by a
// sweep over all MAX_TAPS addresses after reset, on a clear-history beat, and
// when active is written from 0 to 1; no beat is taken during the sweep, though
// register writes are. The result sits in an output register, so the next beat
// is taken while a finished result still waits. Registers (APB, byte address
// 4*index): gain at 0, active at 4, channels_used at 8 (0 and 3 act as 2).
// Configure only while idle. Coefficients have no reset value; write every tap
// that a channel's tap count covers before filtering with it.

module stereo_fir_convolver
  import sfir_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_ready,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_ready,
  output result_t                  result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [GAIN_BITS-1:0] gain;
  logic                 active;
  logic [1:0]           channels_used;
  logic                 cfg_wr;
  reg_index_t           reg_idx;
  logic                 clear_req;
  cmd_t                 cmd;
  stat_t                stat;

  // Zero wait states: every access completes in its access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_index_t'(paddr[3:2]);

  // Switching the filter on while idle wipes the history and the ring position.
  assign clear_req = cfg_wr && (reg_idx == REG_ACTIVE) && pwdata[0] && !active;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain          <= GAIN_RESET;
      active        <= ACTIVE_RESET;
      channels_used <= CHANNELS_USED_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN:          gain          <= pwdata[GAIN_BITS-1:0];
        REG_ACTIVE:        active        <= pwdata[0];
        REG_CHANNELS_USED: channels_used <= pwdata[1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:          prdata = CFG_DATA_BITS'(gain);
      REG_ACTIVE:        prdata = CFG_DATA_BITS'(active);
      REG_CHANNELS_USED: prdata = CFG_DATA_BITS'(channels_used);
      default:           prdata = '0;
    endcase
  end

  // Sequence each beat: decode, walk the taps of each filtering channel of a frame or sweep the history, finish.
  sfir_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .clear_req    (clear_req),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Hold coefficient and history memories, the shared MAC and the output register.
  sfir_datapath #(
    .MAX_TAPS (MAX_TAPS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cmd           (cmd),
    .active        (active),
    .channels_used (channels_used),
    .gain          (gain),
    .stat          (stat),
    .result        (result)
  );

endmodule
